### sv/tds_pkg.sv
package tds_pkg;
    typedef enum logic [3:0] {
        S_IDLE,
        S_FWD_DIV,
        S_FWD_MUL1,
        S_FWD_MUL2,
        S_FWD_WR,
        S_BK_RD,
        S_BK_MUL,
        S_BK_DIV,
        S_BK_OUT
    } t_state;
endpackage

### sv/tds_ram.sv
module tds_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/tds_div.sv
module tds_div #(
    parameter int VW = 48,
    parameter int FB = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [VW-1:0] i_num,
    input  logic signed [VW-1:0] i_den,
    output logic                 o_done,
    output logic signed [VW-1:0] o_quo,
    output logic                 o_err
);
    localparam int NW = VW + FB;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_num, n_num;
    logic [VW-1:0] r_den;
    logic [VW:0]   r_rem, n_rem;
    logic [NW-1:0] r_quo, n_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_neg, r_zero, r_nzneg;
    logic [VW:0]   w_sh;
    logic [VW-1:0] w_mx, w_my;
    logic [NW-1:0] w_lim;
    logic          w_sat;

    assign w_mx = i_num[VW-1] ? VW'(-i_num) : VW'(i_num);
    assign w_my = i_den[VW-1] ? VW'(-i_den) : VW'(i_den);
    assign w_sh = {r_rem[VW-1:0], r_num[NW-1]};

    always_comb begin
        n_num = {r_num[NW-2:0], 1'b0};
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_quo = {r_quo[NW-2:0], 1'b1};
        end else begin
            n_rem = w_sh;
            n_quo = {r_quo[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_den != '0);
                o_done <= (i_den == '0);
            end else if (r_busy) begin
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_num  <= {w_mx, FB'(0)};
            r_den  <= w_my;
            r_rem  <= '0;
            r_quo  <= '0;
            r_cnt  <= CW'(NW);
            r_neg  <= i_num[VW-1] ^ i_den[VW-1];
            r_nzneg <= i_num[VW-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign w_lim = r_neg ? (NW'(1) << (VW-1)) : ((NW'(1) << (VW-1)) - NW'(1));
    assign w_sat = r_quo > w_lim;

    always_comb begin
        if (r_zero) begin
            o_quo = r_nzneg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
            o_err = 1'b1;
        end else begin
            o_err = w_sat;
            if (r_neg) o_quo = w_sat ? {1'b1, {(VW-1){1'b0}}} : VW'(-r_quo);
            else       o_quo = w_sat ? {1'b0, {(VW-1){1'b1}}} : VW'(r_quo);
        end
    end
endmodule

### sv/tds_mul.sv
module tds_mul #(
    parameter int VW = 48,
    parameter int FB = 24
) (
    input  logic                 i_clk,
    input  logic signed [VW-1:0] i_a,
    input  logic signed [VW-1:0] i_b,
    input  logic signed [VW-1:0] i_sub,
    output logic signed [VW-1:0] o_diff
);
    localparam int HW = (VW + 1) / 2;
    localparam int PW = 2 * VW;

    logic [VW-1:0] w_ma, w_mb;
    logic [HW-1:0] w_al, w_ah, w_bl, w_bh;
    logic [2*HW-1:0] r_ll, r_lh, r_hl, r_hh;
    logic          r_neg;
    logic signed [VW-1:0] r_sub;
    logic [PW+2*HW:0] w_full;
    logic [PW+2*HW:0] w_mag;
    logic signed [VW+1:0] w_p, w_d;
    logic signed [VW+1:0] w_max, w_min;

    assign w_ma = i_a[VW-1] ? VW'(-i_a) : VW'(i_a);
    assign w_mb = i_b[VW-1] ? VW'(-i_b) : VW'(i_b);
    assign w_al = HW'(w_ma);
    assign w_ah = HW'(w_ma >> HW);
    assign w_bl = HW'(w_mb);
    assign w_bh = HW'(w_mb >> HW);

    always_ff @(posedge i_clk) begin
        r_ll  <= w_al * w_bl;
        r_lh  <= w_al * w_bh;
        r_hl  <= w_ah * w_bl;
        r_hh  <= w_ah * w_bh;
        r_neg <= i_a[VW-1] ^ i_b[VW-1];
        r_sub <= i_sub;
    end

    assign w_full = ($bits(w_full))'(r_ll) + (($bits(w_full))'(r_lh) << HW)
                  + (($bits(w_full))'(r_hl) << HW) + (($bits(w_full))'(r_hh) << (2*HW));
    assign w_mag = w_full >> FB;
    assign w_max = (VW+2)'((VW+2)'(1) << (VW-1)) - (VW+2)'(1);
    assign w_min = -((VW+2)'(1) << (VW-1));

    always_comb begin
        if (r_neg) begin
            w_p = (w_mag > ($bits(w_mag))'(w_max) + 1) ? w_min : -(VW+2)'(w_mag);
        end else begin
            w_p = (w_mag > ($bits(w_mag))'(w_max)) ? w_max : (VW+2)'(w_mag);
        end
        w_d = (VW+2)'(r_sub) - w_p;
        if (w_d > w_max)      o_diff = VW'(w_max);
        else if (w_d < w_min) o_diff = VW'(w_min);
        else                  o_diff = VW'(w_d);
    end
endmodule

### sv/tridiagonal_solver.sv
// Tridiagonal solver, Thomas algorithm, signed fixed point with 24 fraction bits.
// Input channel: one matrix row per transfer (i_sub_diag, i_main_diag,
// i_super_diag, i_rhs, i_last_row). Forward elimination of that row runs at once.
// Output channel: after the row flagged i_last_row, one unknown per transfer,
// from the last row down to row zero; o_last_result marks row zero and
// o_pivot_error reports a zero pivot or saturated quotient so far in the run.
// Row zero is written straight to the stores; every later row passes through
// the bit-serial restoring divider and then the multiply-subtract unit.
// Each unknown passes through the same divider (the last row, being first,
// skips the multiply-subtract), and is held while the receiver stalls.
// A single multiply-subtract unit (four registered partial products) and three
// RAMs for the eliminated diagonal, super-diagonal and rhs serve all rows.
// o_ready is low while a row or the back substitution is in progress.
// Stalls: the state holds while o_valid is high and i_ready is low.
// Reset clears the row count, the sticky error and all handshakes; stores
// need no clearing since only rows written in the current run are read.
// Rows beyond MAX_ROWS are dropped; a dropped last row still starts solving.
module tridiagonal_solver #(
    parameter int MAX_ROWS    = 64,
    parameter int VALUE_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_sub_diag,
    input  logic signed [VALUE_WIDTH-1:0] i_main_diag,
    input  logic signed [VALUE_WIDTH-1:0] i_super_diag,
    input  logic signed [VALUE_WIDTH-1:0] i_rhs,
    input  logic                          i_last_row,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [VALUE_WIDTH-1:0] o_solution,
    output logic [5:0]                    o_row_index,
    output logic                          o_last_result,
    output logic                          o_pivot_error
);
    import tds_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int FB = 24;
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_idx;
    logic          r_err, r_last, r_first;
    logic signed [VW-1:0] r_b, r_c, r_d, r_m, r_x, r_t;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic signed [VW-1:0] w_wd_diag, w_wd_rhs;
    logic signed [VW-1:0] w_rd_diag, w_rd_up, w_rd_rhs;

    logic          w_div_start, w_div_done, w_div_err;
    logic signed [VW-1:0] w_div_num, w_div_den, w_quo;
    logic signed [VW-1:0] w_mul_a, w_mul_b, w_mul_s, w_diff;
    logic          w_acc;

    assign w_acc = i_valid && o_ready;

    tds_ram #(.WIDTH(VW), .DEPTH(MAX_ROWS)) u_diag (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wd_diag),
        .i_raddr(w_raddr), .o_rdata(w_rd_diag));
    tds_ram #(.WIDTH(VW), .DEPTH(MAX_ROWS)) u_up (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_c),
        .i_raddr(w_raddr), .o_rdata(w_rd_up));
    tds_ram #(.WIDTH(VW), .DEPTH(MAX_ROWS)) u_rhs (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wd_rhs),
        .i_raddr(w_raddr), .o_rdata(w_rd_rhs));

    tds_div #(.VW(VW), .FB(FB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(w_div_den), .o_done(w_div_done),
        .o_quo(w_quo), .o_err(w_div_err));

    tds_mul #(.VW(VW), .FB(FB)) u_mul (
        .i_clk(i_clk), .i_a(w_mul_a), .i_b(w_mul_b), .i_sub(w_mul_s),
        .o_diff(w_diff));

    // state sequence:
    // IDLE -> (row 0) WR | (row n) DIV -> MUL1 -> MUL2 -> WR
    // WR -> IDLE | BK_RD ; BK_RD -> (top) DIV | MUL -> DIV -> OUT -> BK_RD/IDLE
    logic r_sub_ph;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (r_cnt == CW'(MAX_ROWS)) n_state = i_last_row ? S_BK_RD : S_IDLE;
                    else if (r_cnt == '0)       n_state = S_FWD_WR;
                    else                        n_state = S_FWD_DIV;
                end
            end
            S_FWD_DIV:  if (w_div_done) n_state = S_FWD_MUL1;
            S_FWD_MUL1: n_state = S_FWD_MUL2;
            S_FWD_MUL2: n_state = S_FWD_WR;
            S_FWD_WR:   n_state = r_last ? S_BK_RD : S_IDLE;
            S_BK_RD:    if (r_sub_ph) n_state = r_first ? S_BK_DIV : S_BK_MUL;
            S_BK_MUL:   n_state = S_BK_DIV;
            S_BK_DIV:   if (w_div_done) n_state = S_BK_OUT;
            S_BK_OUT:   if (i_ready) n_state = (r_idx == '0) ? S_IDLE : S_BK_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_valid     = (r_state == S_BK_OUT);
        w_we        = (r_state == S_FWD_WR);
        w_waddr     = AW'(r_cnt);
        w_raddr     = (r_state == S_IDLE) ? AW'(r_cnt - CW'(1)) : r_idx;
        w_wd_diag   = (r_cnt == '0) ? r_b : r_t;
        w_wd_rhs    = (r_cnt == '0) ? r_d : w_diff;
        w_div_start = 1'b0;
        w_div_num   = r_t;
        w_div_den   = w_rd_diag;
        w_mul_a     = r_m;
        w_mul_b     = w_rd_up;
        w_mul_s     = r_b;
        unique case (r_state)
            S_FWD_DIV: begin
                w_div_num   = r_t;
                w_div_start = r_sub_ph;
            end
            S_FWD_MUL1: begin
                w_mul_a = w_quo;
                w_mul_b = w_rd_up;
                w_mul_s = r_b;
            end
            S_FWD_MUL2: begin
                w_mul_a = r_m;
                w_mul_b = w_rd_rhs;
                w_mul_s = r_d;
            end
            S_BK_MUL: begin
                w_mul_a = w_rd_up;
                w_mul_b = r_x;
                w_mul_s = w_rd_rhs;
            end
            S_BK_DIV: begin
                w_div_num   = r_first ? w_rd_rhs : w_diff;
                w_div_start = r_sub_ph;
            end
            default: ;
        endcase
    end

    // r_sub_ph: phase flag marking the first cycle in a state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_err    <= 1'b0;
            r_sub_ph <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sub_ph <= (n_state != r_state) || (r_state == S_BK_RD && !r_sub_ph);
            if (r_state == S_FWD_WR) r_cnt <= r_cnt + CW'(1);
            if (w_div_done && w_div_err) r_err <= 1'b1;
            if (r_state == S_BK_OUT && i_ready && r_idx == '0) begin
                r_cnt <= '0;
                r_err <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_b    <= i_main_diag;
            r_c    <= i_super_diag;
            r_d    <= i_rhs;
            r_t    <= i_sub_diag;
            r_last <= i_last_row;
            if (r_cnt == CW'(MAX_ROWS)) begin
                r_idx   <= AW'(r_cnt - CW'(1));
                r_first <= 1'b1;
            end
        end
        if (r_state == S_FWD_DIV && w_div_done) r_m <= w_quo;
        if (r_state == S_FWD_MUL2) r_t <= w_diff;
        if (r_state == S_FWD_WR) begin
            r_idx   <= AW'(r_cnt);
            r_first <= 1'b1;
        end
        if (r_state == S_BK_DIV && w_div_done) begin
            r_x <= w_quo;
            o_solution    <= w_quo;
            o_row_index   <= 6'(r_idx);
            o_last_result <= (r_idx == '0);
            o_pivot_error <= r_err | w_div_err;
        end
        if (r_state == S_BK_OUT && i_ready) begin
            r_idx   <= r_idx - AW'(1);
            r_first <= 1'b0;
        end
    end
endmodule
